// ===== src/cbz_pkg.sv =====
// Shared constants, types and register codes for the Bezier point-to-pixel block.
`default_nettype none

package cbz_pkg;

	// Sample count per segment; a power of two, so the divide by STEPS^3 is a shift
	localparam int STEPS      = 1024;
	localparam int STEPS_LOG2 = $clog2(STEPS);
	localparam int KW         = STEPS_LOG2 + 1;          // k and u = STEPS - k
	localparam int WW         = 3 * STEPS_LOG2 + 1;      // Bernstein weights
	localparam int CW         = 16;                      // coordinate width
	localparam int ACC_W      = 3 * STEPS_LOG2 + CW;     // weighted sum
	localparam int FRAC_W     = 16;                      // Q8.8 -> Q8.24
	localparam int P_SHIFT    = 3 * STEPS_LOG2 - FRAC_W; // acc >> P_SHIFT is Q8.24
	localparam int PW         = 32;                      // curve point, signed Q8.24

	localparam int SMW        = 12;                      // screen max registers
	localparam int EW         = 15;                      // universe extent registers
	localparam int NW         = 45;                      // signed numerator
	localparam int MW         = NW - FRAC_W;             // numerator magnitude >> 16
	localparam int QW         = 20;                      // quotient bits produced
	localparam int DIV_STEP   = 4;                       // quotient bits per stage
	localparam int DIV_STAGES = QW / DIV_STEP;

	localparam int OW         = 16;                      // pixel width
	localparam logic [OW-1:0] PIX_MAX = 16'h7FFF;
	localparam logic [OW-1:0] PIX_MIN = 16'h8000;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y     = 2'd3;

	localparam logic [SMW-1:0] SMX_RST = 12'd639;
	localparam logic [SMW-1:0] SMY_RST = 12'd479;
	localparam logic [EW-1:0]  EXT_RST = 15'd1536;

	// Control points in offset binary (coordinate + 32768), index 0 P0, 1 A, 2 B, 3 P1
	typedef struct packed {
		logic [3:0][CW-1:0] x;
		logic [3:0][CW-1:0] y;
	} ctrl_pts_t;

	// Live configuration; extents already forced nonzero
	typedef struct packed {
		logic [SMW-1:0] smx;
		logic [SMW-1:0] smy;
		logic [EW-1:0]  ex;
		logic [EW-1:0]  ey;
	} cfg_t;

	typedef struct packed {
		logic [MW-1:0] mag;
		logic          neg;
		logic          ovf;
	} div_req_t;

	typedef struct packed {
		logic [QW-1:0] quo;
		logic          neg;
		logic          ovf;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/cbz_bern.sv =====
// Bernstein evaluation pipeline: control points and k to a signed Q8.24 point per axis.
`default_nettype none

module cbz_bern (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire cbz_pkg::ctrl_pts_t         pts,
	input  wire logic [9:0]                 k,
	output logic                            out_valid,
	output logic signed [cbz_pkg::PW-1:0]   p_x,
	output logic signed [cbz_pkg::PW-1:0]   p_y
);

	localparam int KW    = cbz_pkg::KW;
	localparam int WW    = cbz_pkg::WW;
	localparam int CW    = cbz_pkg::CW;
	localparam int ACC_W = cbz_pkg::ACC_W;
	localparam int PW    = cbz_pkg::PW;

	logic [4:0] vld_s;

	// stage 1: clamp k, form u
	logic [KW-1:0] k_c;
	logic [KW-1:0] k_s1, u_s1;
	cbz_pkg::ctrl_pts_t pts_s1;

	assign k_c = (KW'(k) > KW'(cbz_pkg::STEPS)) ? KW'(cbz_pkg::STEPS) : KW'(k);

	// stage 2: squares and cross term
	logic [2*KW-1:0] kk, uu, ku;
	logic [2*KW-1:0] kk_s2, uu_s2, ku_s2;
	logic [KW-1:0]   k_s2, u_s2;
	cbz_pkg::ctrl_pts_t pts_s2;

	assign kk = k_s1 * k_s1;
	assign uu = u_s1 * u_s1;
	assign ku = k_s1 * u_s1;

	// stage 3: weights u^3, 3ku^2, 3k^2u, k^3
	logic [3*KW-1:0] uuu, kuu, kku, kkk;
	logic [3:0][WW-1:0] w, w_s3;
	cbz_pkg::ctrl_pts_t pts_s3;

	assign uuu = uu_s2 * u_s2;
	assign kuu = ku_s2 * u_s2;
	assign kku = kk_s2 * u_s2;
	assign kkk = kk_s2 * k_s2;
	assign w[0] = WW'(uuu);
	assign w[1] = WW'(kuu + (kuu << 1));
	assign w[2] = WW'(kku + (kku << 1));
	assign w[3] = WW'(kkk);

	// stage 4: weight times coordinate
	logic [3:0][WW+CW-1:0]  prx, pry;
	logic [3:0][ACC_W-1:0]  prx_s4, pry_s4;

	for (genvar j = 0; j < 4; j++) begin : g_prod
		assign prx[j] = w_s3[j] * pts_s3.x[j];
		assign pry[j] = w_s3[j] * pts_s3.y[j];
	end

	// stage 5: sum, scale by 2^16 / STEPS^3 (floor), remove the offset
	logic [ACC_W-1:0] acc_x, acc_y;
	logic [PW-1:0]    off_x, off_y;
	logic signed [PW-1:0] p_x_s5, p_y_s5;

	assign acc_x = prx_s4[0] + prx_s4[1] + prx_s4[2] + prx_s4[3];
	assign acc_y = pry_s4[0] + pry_s4[1] + pry_s4[2] + pry_s4[3];
	assign off_x = acc_x[cbz_pkg::P_SHIFT +: PW];
	assign off_y = acc_y[cbz_pkg::P_SHIFT +: PW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1   <= k_c;
			u_s1   <= KW'(cbz_pkg::STEPS) - k_c;
			pts_s1 <= pts;

			kk_s2  <= kk;
			uu_s2  <= uu;
			ku_s2  <= ku;
			k_s2   <= k_s1;
			u_s2   <= u_s1;
			pts_s2 <= pts_s1;

			w_s3   <= w;
			pts_s3 <= pts_s2;

			for (int j = 0; j < 4; j++) begin
				prx_s4[j] <= ACC_W'(prx[j]);
				pry_s4[j] <= ACC_W'(pry[j]);
			end

			// subtracting 2^31 from the offset value flips its top bit
			p_x_s5 <= {~off_x[PW-1], off_x[PW-2:0]};
			p_y_s5 <= {~off_y[PW-1], off_y[PW-2:0]};
		end
	end

	assign out_valid = vld_s[4];
	assign p_x       = p_x_s5;
	assign p_y       = p_y_s5;

endmodule

`default_nettype wire

// ===== src/cbz_map.sv =====
// Screen mapping: scales the curve point and splits it into sign and magnitude for the divider.
`default_nettype none

module cbz_map (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic signed [cbz_pkg::PW-1:0] p_x,
	input  wire logic signed [cbz_pkg::PW-1:0] p_y,
	input  wire cbz_pkg::cfg_t               cfg,
	output logic                             out_valid,
	output cbz_pkg::div_req_t                req_x,
	output cbz_pkg::div_req_t                req_y
);

	localparam int PW     = cbz_pkg::PW;
	localparam int SMW    = cbz_pkg::SMW;
	localparam int NW     = cbz_pkg::NW;
	localparam int MW     = cbz_pkg::MW;
	localparam int QW     = cbz_pkg::QW;
	localparam int EW     = cbz_pkg::EW;
	localparam int FRAC_W = cbz_pkg::FRAC_W;

	logic [1:0] vld_s;

	// stage 6: numerators smx * p and smy * (ey * 2^16 - p)
	logic signed [PW:0]          d_y;
	logic signed [SMW+PW:0]      nx_full;
	logic signed [SMW+PW+1:0]    ny_full;
	logic signed [NW-1:0]        n_x_s6, n_y_s6;

	assign d_y     = $signed({2'b00, cfg.ey, {FRAC_W{1'b0}}}) - $signed({p_y[PW-1], p_y});
	assign nx_full = $signed({1'b0, cfg.smx}) * p_x;
	assign ny_full = $signed({1'b0, cfg.smy}) * d_y;

	// stage 7: |n| >> 16, then the divide toward zero works on magnitudes
	logic [NW-1:0] mag_x, mag_y;
	logic [MW-1:0] m_x, m_y;
	cbz_pkg::div_req_t req_x_s7, req_y_s7;

	assign mag_x = n_x_s6[NW-1] ? NW'(-n_x_s6) : NW'(n_x_s6);
	assign mag_y = n_y_s6[NW-1] ? NW'(-n_y_s6) : NW'(n_y_s6);
	assign m_x   = mag_x[NW-1:FRAC_W];
	assign m_y   = mag_y[NW-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_x_s6 <= NW'(nx_full);
			n_y_s6 <= NW'(ny_full);

			req_x_s7.mag <= m_x;
			req_x_s7.neg <= n_x_s6[NW-1];
			// quotient would need more than QW bits: saturates anyway
			req_x_s7.ovf <= EW'(m_x[MW-1:QW]) >= cfg.ex;
			req_y_s7.mag <= m_y;
			req_y_s7.neg <= n_y_s6[NW-1];
			req_y_s7.ovf <= EW'(m_y[MW-1:QW]) >= cfg.ey;
		end
	end

	assign out_valid = vld_s[1];
	assign req_x     = req_x_s7;
	assign req_y     = req_y_s7;

endmodule

`default_nettype wire

// ===== src/cbz_div.sv =====
// Pipelined restoring divider: magnitude / extent, a few quotient bits per stage.
`default_nettype none

module cbz_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire cbz_pkg::div_req_t       req,
	input  wire logic [cbz_pkg::EW-1:0]  divisor,
	output logic                         out_valid,
	output cbz_pkg::div_rsp_t            rsp
);

	localparam int EW     = cbz_pkg::EW;
	localparam int MW     = cbz_pkg::MW;
	localparam int QW     = cbz_pkg::QW;
	localparam int NSTG   = cbz_pkg::DIV_STAGES;

	typedef struct packed {
		logic [EW-1:0] rem;
		logic [QW-1:0] dvd;
		logic [QW-1:0] quo;
		logic          neg;
		logic          ovf;
	} div_stage_t;

	function automatic div_stage_t div_step(input div_stage_t s, input logic [EW-1:0] d);
		div_stage_t  r;
		logic [EW:0] t;
		r = s;
		for (int i = 0; i < cbz_pkg::DIV_STEP; i++) begin
			t     = {r.rem, r.dvd[QW-1]};
			r.dvd = {r.dvd[QW-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				r.rem = EW'(t - {1'b0, d});
				r.quo = {r.quo[QW-2:0], 1'b1};
			end else begin
				r.rem = t[EW-1:0];
				r.quo = {r.quo[QW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	div_stage_t        init;
	div_stage_t        nxt   [NSTG];
	div_stage_t        stg_s [NSTG];
	logic [NSTG-1:0]   vld_s;

	// high bits start the remainder; they are below the divisor unless ovf is set
	assign init.rem = EW'(req.mag[MW-1:QW]);
	assign init.dvd = req.mag[QW-1:0];
	assign init.quo = '0;
	assign init.neg = req.neg;
	assign init.ovf = req.ovf;

	assign nxt[0] = div_step(init, divisor);
	for (genvar i = 1; i < NSTG; i++) begin : g_stage
		assign nxt[i] = div_step(stg_s[i-1], divisor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s <= nxt;
		end
	end

	assign out_valid = vld_s[NSTG-1];
	assign rsp.quo   = stg_s[NSTG-1].quo;
	assign rsp.neg   = stg_s[NSTG-1].neg;
	assign rsp.ovf   = stg_s[NSTG-1].ovf;

endmodule

`default_nettype wire

// ===== src/cubic_bezier_point_to_pixel.sv =====
// Top level: cubic Bezier sample to screen pixel, configuration registers and output stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries the four control points of one
//   cubic segment in signed Q8.8 and a sample index k; t = k / 1024.
//   Output channel (out_valid / out_stall) returns one item per input item:
//   pixel_x, pixel_y (y flipped) and on_screen, in input order.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   screen_max_x, screen_max_y, universe_extent_x, universe_extent_y at
//   indexes 0..3; cfg_ready is always high. Write only while the block is idle.
//   The pipeline has 5 Bernstein stages, 2 mapping stages, 5 divider
//   stages at 4 quotient bits each, and the output register.
//   Throughput is one item per cycle unless stalled; every stage is a plain register step.
//   A stall on a valid output item freezes the whole pipeline in place, and in_stall
//   rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and loads 639, 479, 1536, 1536 into the
//   registers; the block can take an item as soon as reset is released.
`default_nettype none

module cubic_bezier_point_to_pixel (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [15:0]                start_x,
	input  wire logic signed [15:0]                start_y,
	input  wire logic signed [15:0]                end_x,
	input  wire logic signed [15:0]                end_y,
	input  wire logic signed [15:0]                ctrl_a_x,
	input  wire logic signed [15:0]                ctrl_a_y,
	input  wire logic signed [15:0]                ctrl_b_x,
	input  wire logic signed [15:0]                ctrl_b_y,
	input  wire logic [9:0]                        sample_index,

	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [15:0]                     pixel_x,
	output logic signed [15:0]                     pixel_y,
	output logic                                   on_screen,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cbz_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cbz_pkg::CFG_DW-1:0]        cfg_data
);

	localparam int SMW = cbz_pkg::SMW;
	localparam int EW  = cbz_pkg::EW;
	localparam int QW  = cbz_pkg::QW;
	localparam int OW  = cbz_pkg::OW;

	// configuration registers
	logic [SMW-1:0] smx_q, smy_q;
	logic [EW-1:0]  ex_q, ey_q;
	cbz_pkg::cfg_t  cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smx_q <= cbz_pkg::SMX_RST;
			smy_q <= cbz_pkg::SMY_RST;
			ex_q  <= cbz_pkg::EXT_RST;
			ey_q  <= cbz_pkg::EXT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbz_pkg::CFG_SCREEN_MAX_X: smx_q <= cfg_data[SMW-1:0];
				cbz_pkg::CFG_SCREEN_MAX_Y: smy_q <= cfg_data[SMW-1:0];
				cbz_pkg::CFG_EXTENT_X:     ex_q  <= cfg_data[EW-1:0];
				cbz_pkg::CFG_EXTENT_Y:     ey_q  <= cfg_data[EW-1:0];
				default: ;
			endcase
		end
	end

	// an extent of zero acts as one
	assign cfg.smx = smx_q;
	assign cfg.smy = smy_q;
	assign cfg.ex  = (ex_q == '0) ? EW'(1) : ex_q;
	assign cfg.ey  = (ey_q == '0) ? EW'(1) : ey_q;

	// pipeline advance: the whole pipe holds while a finished item is stalled
	logic en;
	logic out_valid_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// control points in offset binary
	cbz_pkg::ctrl_pts_t pts;

	assign pts.x[0] = {~start_x[15],  start_x[14:0]};
	assign pts.x[1] = {~ctrl_a_x[15], ctrl_a_x[14:0]};
	assign pts.x[2] = {~ctrl_b_x[15], ctrl_b_x[14:0]};
	assign pts.x[3] = {~end_x[15],    end_x[14:0]};
	assign pts.y[0] = {~start_y[15],  start_y[14:0]};
	assign pts.y[1] = {~ctrl_a_y[15], ctrl_a_y[14:0]};
	assign pts.y[2] = {~ctrl_b_y[15], ctrl_b_y[14:0]};
	assign pts.y[3] = {~end_y[15],    end_y[14:0]};

	logic                           bern_valid;
	logic signed [cbz_pkg::PW-1:0]  p_x, p_y;

	cbz_bern u_bern (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.pts       (pts),
		.k         (sample_index),
		.out_valid (bern_valid),
		.p_x       (p_x),
		.p_y       (p_y)
	);

	logic               map_valid;
	cbz_pkg::div_req_t  req_x, req_y;

	cbz_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (bern_valid),
		.p_x       (p_x),
		.p_y       (p_y),
		.cfg       (cfg),
		.out_valid (map_valid),
		.req_x     (req_x),
		.req_y     (req_y)
	);

	logic               dvx_valid, dvy_valid;
	cbz_pkg::div_rsp_t  rsp_x, rsp_y;

	cbz_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (map_valid),
		.req       (req_x),
		.divisor   (cfg.ex),
		.out_valid (dvx_valid),
		.rsp       (rsp_x)
	);

	cbz_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (map_valid),
		.req       (req_y),
		.divisor   (cfg.ey),
		.out_valid (dvy_valid),
		.rsp       (rsp_y)
	);

	// signed, saturated pixel from quotient magnitude and sign
	function automatic logic [OW-1:0] sat_pix(input cbz_pkg::div_rsp_t r);
		logic [OW-1:0] res;
		if (r.neg) begin
			if (r.ovf || r.quo > QW'(32768)) res = cbz_pkg::PIX_MIN;
			else                             res = OW'(~r.quo[OW-1:0] + 1'b1);
		end else begin
			if (r.ovf || r.quo > QW'(32767)) res = cbz_pkg::PIX_MAX;
			else                             res = r.quo[OW-1:0];
		end
		return res;
	endfunction

	function automatic logic in_range(input logic [OW-1:0] g, input logic [SMW-1:0] lim);
		return !g[OW-1] && (g[OW-2:0] <= (OW-1)'(lim));
	endfunction

	logic [OW-1:0] gx, gy;
	logic [OW-1:0] pixel_x_q, pixel_y_q;
	logic          on_screen_q;

	assign gx = sat_pix(rsp_x);
	assign gy = sat_pix(rsp_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dvx_valid && dvy_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_x_q   <= gx;
			pixel_y_q   <= gy;
			on_screen_q <= in_range(gx, smx_q) && in_range(gy, smy_q);
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign on_screen = on_screen_q;

	// an on-screen pixel never has a negative coordinate
	a_on_screen_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_screen |-> !pixel_x[OW-1] && !pixel_y[OW-1])
		else $error("on_screen set with a negative pixel coordinate");

	// a quotient overflow must come out saturated
	a_ovf_sat_x: assert property (@(posedge clk) disable iff (!arst_n)
		en && dvx_valid && rsp_x.ovf |=>
			(pixel_x_q == cbz_pkg::PIX_MAX) || (pixel_x_q == cbz_pkg::PIX_MIN))
		else $error("x divider overflow not saturated");

	a_ovf_sat_y: assert property (@(posedge clk) disable iff (!arst_n)
		en && dvy_valid && rsp_y.ovf |=>
			(pixel_y_q == cbz_pkg::PIX_MAX) || (pixel_y_q == cbz_pkg::PIX_MIN))
		else $error("y divider overflow not saturated");

	// both axis dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dvx_valid == dvy_valid)
		else $error("x and y divider valids disagree");

endmodule

`default_nettype wire

// ===== tb/cubic_bezier_point_to_pixel_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Bezier point-to-pixel block: predicts each pixel item and compares the outputs.
module cubic_bezier_point_to_pixel_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic signed [15:0]            start_x,
	input  wire logic signed [15:0]            start_y,
	input  wire logic signed [15:0]            end_x,
	input  wire logic signed [15:0]            end_y,
	input  wire logic signed [15:0]            ctrl_a_x,
	input  wire logic signed [15:0]            ctrl_a_y,
	input  wire logic signed [15:0]            ctrl_b_x,
	input  wire logic signed [15:0]            ctrl_b_y,
	input  wire logic [9:0]                    sample_index,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic signed [15:0]            pixel_x,
	input  wire logic signed [15:0]            pixel_y,
	input  wire logic                          on_screen,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [cbz_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cbz_pkg::CFG_DW-1:0]    cfg_data,
	output int                                 errors,
	output int                                 pending,
	output int                                 checked,
	output int                                 on_hits
);

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               visible;
	} pixel_t;

	logic [cbz_pkg::SMW-1:0] smx = cbz_pkg::SMX_RST;
	logic [cbz_pkg::SMW-1:0] smy = cbz_pkg::SMY_RST;
	logic [cbz_pkg::EW-1:0]  ext_x = cbz_pkg::EXT_RST;
	logic [cbz_pkg::EW-1:0]  ext_y = cbz_pkg::EXT_RST;
	pixel_t                  pixel_q[$];
	pixel_t                  want;

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
		on_hits = 0;
	end

	// Exact Bernstein sum in offset binary, floored to signed Q8.24
	function automatic longint curve_q24(input logic [15:0] p0, input logic [15:0] a,
		input logic [15:0] b, input logic [15:0] p1, input longint unsigned k);
		longint unsigned s, u, s3, acc, q, r, off;
		s   = cbz_pkg::STEPS;
		u   = s - k;
		s3  = s * s * s;
		acc = u * u * u * (p0 ^ 16'h8000)
		    + 3 * k * u * u * (a ^ 16'h8000)
		    + 3 * k * k * u * (b ^ 16'h8000)
		    + k * k * k * (p1 ^ 16'h8000);
		q   = acc / s3;
		r   = acc % s3;
		off = (q << 16) + ((r << 16) / s3);
		return longint'(off) - (longint'(32768) << 16);
	endfunction

	function automatic longint sat_pixel(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic pixel_t predict_pixel(input logic [15:0] sx, input logic [15:0] sy,
		input logic [15:0] fx, input logic [15:0] fy, input logic [15:0] ax,
		input logic [15:0] ay, input logic [15:0] bx, input logic [15:0] by,
		input logic [9:0] idx);
		longint unsigned k;
		longint          cx, cy, dx, dy, gx, gy;
		pixel_t          res;
		k = idx;
		if (k > cbz_pkg::STEPS)
			k = cbz_pkg::STEPS;
		cx = curve_q24(sx, ax, bx, fx, k);
		cy = curve_q24(sy, ay, by, fy, k);
		// zero extent acts as one
		dx = longint'(ext_x == '0 ? 15'd1 : ext_x) * 65536;
		dy = longint'(ext_y == '0 ? 15'd1 : ext_y) * 65536;
		// longint division truncates toward zero
		gx = sat_pixel((longint'(smx) * cx) / dx);
		gy = sat_pixel((longint'(smy) * (dy - cy)) / dy);
		res.px      = gx[15:0];
		res.py      = gy[15:0];
		res.visible = gx >= 0 && gx <= longint'(smx) && gy >= 0 && gy <= longint'(smy);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smx   = cbz_pkg::SMX_RST;
			smy   = cbz_pkg::SMY_RST;
			ext_x = cbz_pkg::EXT_RST;
			ext_y = cbz_pkg::EXT_RST;
			pixel_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cbz_pkg::CFG_SCREEN_MAX_X: smx   = cfg_data[cbz_pkg::SMW-1:0];
					cbz_pkg::CFG_SCREEN_MAX_Y: smy   = cfg_data[cbz_pkg::SMW-1:0];
					cbz_pkg::CFG_EXTENT_X:     ext_x = cfg_data[cbz_pkg::EW-1:0];
					cbz_pkg::CFG_EXTENT_Y:     ext_y = cfg_data[cbz_pkg::EW-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pixel_q.push_back(predict_pixel(start_x, start_y, end_x, end_y,
					ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, sample_index));
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					$error("pixel item with nothing expected: pixel_x %0d pixel_y %0d",
						pixel_x, pixel_y);
					errors++;
				end else begin
					want = pixel_q.pop_front();
					if (pixel_x !== want.px) begin
						$error("pixel_x: expected %0d, got %0d", $signed(want.px), pixel_x);
						errors++;
					end
					if (pixel_y !== want.py) begin
						$error("pixel_y: expected %0d, got %0d", $signed(want.py), pixel_y);
						errors++;
					end
					if (on_screen !== want.visible) begin
						$error("on_screen: expected %0b, got %0b", want.visible, on_screen);
						errors++;
					end
					checked++;
					if (want.visible)
						on_hits++;
				end
			end
			pending = pixel_q.size();
		end
	end

endmodule

// ===== tb/cubic_bezier_point_to_pixel_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives curve samples and register settings into the pixel mapper and reports.
module cubic_bezier_point_to_pixel_tb;

	localparam int LATENCY         = 13;
	localparam int STALL_LIMIT     = 2000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 200;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [15:0]            start_x = '0;
	logic signed [15:0]            start_y = '0;
	logic signed [15:0]            end_x = '0;
	logic signed [15:0]            end_y = '0;
	logic signed [15:0]            ctrl_a_x = '0;
	logic signed [15:0]            ctrl_a_y = '0;
	logic signed [15:0]            ctrl_b_x = '0;
	logic signed [15:0]            ctrl_b_y = '0;
	logic [9:0]                    sample_index = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [15:0]            pixel_x;
	logic signed [15:0]            pixel_y;
	logic                          on_screen;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [cbz_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cbz_pkg::CFG_DW-1:0]    cfg_data = '0;

	logic quiet = 1'b0;
	int   win_x = cbz_pkg::EXT_RST;
	int   win_y = cbz_pkg::EXT_RST;
	int   settings = 0;
	int   sent = 0;
	int   idle_cycles = 0;
	int   chk_errors, chk_pending, chk_count, chk_on;

	always #5 clk = ~clk;

	cubic_bezier_point_to_pixel uut (.*);

	cubic_bezier_point_to_pixel_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall,
		.start_x, .start_y, .end_x, .end_y,
		.ctrl_a_x, .ctrl_a_y, .ctrl_b_x, .ctrl_b_y, .sample_index,
		.out_valid, .out_stall, .pixel_x, .pixel_y, .on_screen,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors(chk_errors), .pending(chk_pending), .checked(chk_count), .on_hits(chk_on)
	);

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 9);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_item(input logic signed [15:0] sx, input logic signed [15:0] sy,
		input logic signed [15:0] fx, input logic signed [15:0] fy,
		input logic signed [15:0] ax, input logic signed [15:0] ay,
		input logic signed [15:0] bx, input logic signed [15:0] by, input logic [9:0] k);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		start_x      <= sx;
		start_y      <= sy;
		end_x        <= fx;
		end_y        <= fy;
		ctrl_a_x     <= ax;
		ctrl_a_y     <= ay;
		ctrl_b_x     <= bx;
		ctrl_b_y     <= by;
		sample_index <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// mode below 5: near the universe window; below 8: any value; else corner values
	function automatic logic [15:0] rand_coord(input int mode, input int ext);
		int v;
		if (mode < 5) begin
			v = int'($urandom_range(ext + ext / 8)) - ext / 16;
			if (v > 32767)
				v = 32767;
			return v[15:0];
		end
		if (mode < 8)
			return 16'($urandom_range(16'hFFFF));
		case ($urandom_range(3))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic send_random();
		int         mode;
		logic [9:0] k;
		mode = $urandom_range(9);
		case ($urandom_range(15))
			0:       k = 10'd0;
			1:       k = 10'd1023;
			default: k = 10'($urandom_range(1023));
		endcase
		send_item(rand_coord(mode, win_x), rand_coord(mode, win_y),
			rand_coord(mode, win_x), rand_coord(mode, win_y),
			rand_coord(mode, win_x), rand_coord(mode, win_y),
			rand_coord(mode, win_x), rand_coord(mode, win_y), k);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [cbz_pkg::CFG_IDX_W-1:0] idx,
		input logic [cbz_pkg::CFG_DW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_config(input logic [14:0] d_smx, input logic [14:0] d_smy,
		input logic [14:0] d_ex, input logic [14:0] d_ey);
		write_reg(cbz_pkg::CFG_SCREEN_MAX_X, d_smx);
		write_reg(cbz_pkg::CFG_SCREEN_MAX_Y, d_smy);
		write_reg(cbz_pkg::CFG_EXTENT_X, d_ex);
		write_reg(cbz_pkg::CFG_EXTENT_Y, d_ey);
		cfg_valid <= 1'b0;
		win_x = (d_ex == 0) ? 1 : d_ex;
		win_y = (d_ey == 0) ? 1 : d_ey;
		settings++;
	endtask

	initial begin
		int ph, n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: 6.0 x 6.0 onto 640 x 480
		send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
		send_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1023);
		send_item(0, 0, 1536, 1536, 512, 1024, 1024, 512, 512);
		// x just below zero truncates to column 0, y at the extent maps to row 0
		send_item(-1, 1536, 0, 0, 0, 0, 0, 0, 0);
		send_item(1536, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(0, 0, 1536, 1536, 0, 0, 1536, 1536, 1023);
		send_item(0, 0, 0, 0, 32767, 32767, -32768, -32768, 341);
		send_item(-32768, 32767, 32767, -32768, 0, 0, 0, 0, 1);
		send_item(-32768, 32767, 32767, -32768, 0, 0, 0, 0, 1022);
		send_item(100, 200, 1400, 1300, -500, 1800, 2000, -300, 700);
		send_item(-1, -1, -1, -1, -1, -1, -1, -1, 300);
		send_item(1540, -10, 1540, -10, 1540, -10, 1540, -10, 900);
		send_item(1537, 1537, 0, 0, 0, 0, 0, 0, 0);
		send_item(-300, 1700, 1800, -200, 32767, -32768, -32768, 32767, 511);

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: apply_config(15'(cbz_pkg::SMX_RST), 15'(cbz_pkg::SMY_RST),
					cbz_pkg::EXT_RST, cbz_pkg::EXT_RST);
				1: apply_config(4095, 4095, 32767, 32767);
				2: apply_config(1, 1, 1, 1);
				3: apply_config(0, 0, 0, 0);
				4: apply_config(4095, 4095, 1, 1);
				// raw 15-bit writes, upper bits of the screen registers are dropped
				5: apply_config(15'($urandom_range(32767)), 15'($urandom_range(32767)),
					15'($urandom_range(32767)), 15'($urandom_range(32767)));
				default: apply_config(15'($urandom_range(1, 4095)),
					15'($urandom_range(1, 4095)),
					15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)));
			endcase
			quiet <= (ph == 6);
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_random();
		end

		drain();
		quiet <= 1'b0;
		repeat (LATENCY + 8) @(posedge clk);
		$display("%0d curve samples sent under %0d register settings, %0d results checked",
			sent, settings, chk_count);
		$display("%0d results landed on screen", chk_on);
		if (chk_errors == 0 && chk_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
